// ===== rtl/greedy_box_nms_macros.svh =====
// ----------------------------------------------------------------------------
// greedy_box_nms assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_IMPLY(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("greedy_box_nms: implication check failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("greedy_box_nms: next-cycle check failed");

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the box suppression controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int SCORE_W        = 32;
  localparam int THR_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [THR_W-1:0]     THR_RESET    = 16'd19661;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'b1;
  localparam logic [2:0]           DRAIN_CYCLES = 3'd6;

  typedef struct packed {
    logic nb_load;
    logic wr_en;
    logic wr_sel_new;
    logic keep_set;
    logic lat_a;
    logic lat_area;
    logic pair_issue;
    logic pend_load;
    logic emit;
    logic emit_last;
    logic ovf;
  } gbn_cmd_t;

  typedef struct packed {
    logic lt;
    logic keep_rd;
  } gbn_sts_t;

endpackage

// ===== rtl/greedy_box_nms.sv =====
// Sequence: each accepted box load holds busy while it is shifted into score order among
// the stored boxes. The last box then starts the sweeps: each kept box is tested against
// every later box still kept, then the survivors are scanned and emitted.
// Throughput: one batch at a time; results come one per strobe and cannot be stalled.
// Reset: asynchronous, clears the controller and batch count; threshold 19661, mode 0.
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression of scored boxes, emitted in score order.
// ----------------------------------------------------------------------------
module greedy_box_nms import gbn_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_BITS-1:0]     box_x_i,
  input  logic [COORD_BITS-1:0]     box_y_i,
  input  logic [COORD_BITS-1:0]     box_width_i,
  input  logic [COORD_BITS-1:0]     box_height_i,
  input  logic signed [SCORE_W-1:0] box_score_i,
  input  logic                      last_box_i,
  output logic                      kept_valid_o,
  output logic [COORD_BITS-1:0]     kept_x_o,
  output logic [COORD_BITS-1:0]     kept_y_o,
  output logic [COORD_BITS-1:0]     kept_width_o,
  output logic [COORD_BITS-1:0]     kept_height_o,
  output logic signed [SCORE_W-1:0] kept_score_o,
  output logic                      last_kept_o,
  output logic                      batch_overflow_o
);

  localparam int AW = $clog2(MAX_BOXES);

  gbn_cmd_t      cmd;
  gbn_sts_t      sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] kset_addr;

  gbn_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_box_i  (last_box_i),
    .busy        (busy),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .kset_addr_o (kset_addr)
  );

  gbn_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .box_x_i          (box_x_i),
    .box_y_i          (box_y_i),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .box_score_i      (box_score_i),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .wr_addr_i        (wr_addr),
    .kset_addr_i      (kset_addr),
    .sts_o            (sts),
    .kept_valid_o     (kept_valid_o),
    .kept_x_o         (kept_x_o),
    .kept_y_o         (kept_y_o),
    .kept_width_o     (kept_width_o),
    .kept_height_o    (kept_height_o),
    .kept_score_o     (kept_score_o),
    .last_kept_o      (last_kept_o),
    .batch_overflow_o (batch_overflow_o)
  );

endmodule

// ===== rtl/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// gbn_datapath
// Box store, keep marks, pairwise overlap pipeline, config and result words.
// ----------------------------------------------------------------------------
module gbn_datapath import gbn_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic [COORD_BITS-1:0]        box_x_i,
  input  logic [COORD_BITS-1:0]        box_y_i,
  input  logic [COORD_BITS-1:0]        box_width_i,
  input  logic [COORD_BITS-1:0]        box_height_i,
  input  logic signed [SCORE_W-1:0]    box_score_i,
  input  gbn_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_BOXES)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_BOXES)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_BOXES)-1:0] kset_addr_i,
  output gbn_sts_t                     sts_o,
  output logic                         kept_valid_o,
  output logic [COORD_BITS-1:0]        kept_x_o,
  output logic [COORD_BITS-1:0]        kept_y_o,
  output logic [COORD_BITS-1:0]        kept_width_o,
  output logic [COORD_BITS-1:0]        kept_height_o,
  output logic signed [SCORE_W-1:0]    kept_score_o,
  output logic                         last_kept_o,
  output logic                         batch_overflow_o
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CB = COORD_BITS;
  localparam int GW = 4 * CB;
  localparam int RW = GW + SCORE_W;
  localparam int DW = 2 * CB + 1;
  localparam int PW = THR_W + DW;

  logic [THR_W-1:0] thr_q;
  logic             mode_q;

  logic [RW-1:0] nb_q;
  logic [RW-1:0] rdata;
  logic [RW-1:0] wdata;
  logic          keep_rdata;
  logic          keep_we;
  logic [AW-1:0] keep_waddr;
  logic          sup;

  logic [CB-1:0] rx, ry, rw, rh;
  logic signed [SCORE_W-1:0] rscore;

  logic [CB-1:0]   ax_q, ay_q, aw_q, ah_q;
  logic [2*CB-1:0] area_a_q;

  logic          v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0] j0_q, j1_q, j2_q, j3_q, j4_q;
  logic          pos1_q, pos2_q, pos3_q, pos4_q;
  logic [CB-1:0] iw1_q, ih1_q, bw1_q, bh1_q;
  logic [2*CB-1:0] inter2_q, ab2_q, inter3_q, inter4_q;
  logic [DW-1:0]   den3_q;
  logic [PW-1:0]   prod4_q;

  logic [CB:0]   ax2, ay2, bx2, by2, min_x2, min_y2;
  logic [CB-1:0] max_x, max_y;
  logic signed [CB+1:0] iw_s, ih_s;
  logic [DW-1:0] den_d;

  logic [RW-1:0] pend_q;
  logic [RW-1:0] out_q;
  logic          out_v_q, out_last_q, out_ovf_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_IDX_THR:  thr_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_IDX_MODE: mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_load) begin
      nb_q <= {box_score_i, box_height_i, box_width_i, box_y_i, box_x_i};
    end
  end

  assign wdata = cmd_i.wr_sel_new ? nb_q : rdata;

  gbn_ram #(.WIDTH(RW), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign keep_we    = cmd_i.keep_set | sup;
  assign keep_waddr = sup ? j4_q : kset_addr_i;

  gbn_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_keep_ram (
    .clk_i   (clk_i),
    .we_i    (keep_we),
    .waddr_i (keep_waddr),
    .wdata_i (~sup),
    .raddr_i (rd_addr_i),
    .rdata_o (keep_rdata)
  );

  assign rx     = rdata[CB-1:0];
  assign ry     = rdata[2*CB-1:CB];
  assign rw     = rdata[3*CB-1:2*CB];
  assign rh     = rdata[4*CB-1:3*CB];
  assign rscore = $signed(rdata[RW-1:GW]);

  assign sts_o.lt      = rscore < $signed(nb_q[RW-1:GW]);
  assign sts_o.keep_rd = keep_rdata;

  // reference box of the current sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      ax_q <= rx;
      ay_q <= ry;
      aw_q <= rw;
      ah_q <= rh;
    end
    if (cmd_i.lat_area) begin
      area_a_q <= (2*CB)'(aw_q) * (2*CB)'(ah_q);
    end
  end

  assign ax2    = {1'b0, ax_q} + {1'b0, aw_q};
  assign ay2    = {1'b0, ay_q} + {1'b0, ah_q};
  assign bx2    = {1'b0, rx} + {1'b0, rw};
  assign by2    = {1'b0, ry} + {1'b0, rh};
  assign min_x2 = (ax2 < bx2) ? ax2 : bx2;
  assign min_y2 = (ay2 < by2) ? ay2 : by2;
  assign max_x  = (ax_q > rx) ? ax_q : rx;
  assign max_y  = (ay_q > ry) ? ay_q : ry;
  assign iw_s   = $signed({1'b0, min_x2}) - $signed({2'b00, max_x});
  assign ih_s   = $signed({1'b0, min_y2}) - $signed({2'b00, max_y});

  always_comb begin
    if (mode_q) begin
      den_d = {1'b0, (area_a_q < ab2_q) ? area_a_q : ab2_q};
    end else begin
      den_d = {1'b0, area_a_q} + {1'b0, ab2_q} - {1'b0, inter2_q};
    end
  end

  assign sup = v4_q & pos4_q & ({{(PW-2*CB-THR_W){1'b0}}, inter4_q, {THR_W{1'b0}}} > prod4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.pair_issue;
      v1_q <= v0_q & keep_rdata;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j0_q     <= rd_addr_i;
    j1_q     <= j0_q;
    pos1_q   <= (iw_s > 0) && (ih_s > 0);
    iw1_q    <= iw_s[CB-1:0];
    ih1_q    <= ih_s[CB-1:0];
    bw1_q    <= rw;
    bh1_q    <= rh;
    j2_q     <= j1_q;
    pos2_q   <= pos1_q;
    inter2_q <= (2*CB)'(iw1_q) * (2*CB)'(ih1_q);
    ab2_q    <= (2*CB)'(bw1_q) * (2*CB)'(bh1_q);
    j3_q     <= j2_q;
    pos3_q   <= pos2_q;
    inter3_q <= inter2_q;
    den3_q   <= den_d;
    j4_q     <= j3_q;
    pos4_q   <= pos3_q;
    inter4_q <= inter3_q;
    prod4_q  <= PW'(thr_q) * PW'(den3_q);
  end

  // result words
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_q <= rdata;
    end
    if (cmd_i.emit) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.emit_last;
      out_ovf_q  <= cmd_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cmd_i.emit;
    end
  end

  assign kept_valid_o     = out_v_q;
  assign kept_x_o         = out_q[CB-1:0];
  assign kept_y_o         = out_q[2*CB-1:CB];
  assign kept_width_o     = out_q[3*CB-1:2*CB];
  assign kept_height_o    = out_q[4*CB-1:3*CB];
  assign kept_score_o     = $signed(out_q[RW-1:GW]);
  assign last_kept_o      = out_last_q;
  assign batch_overflow_o = out_ovf_q;

endmodule

// ===== rtl/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer for sorted insertion, suppression sweeps and result emission.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_macros.svh"

module gbn_ctrl import gbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         last_box_i,
  output logic                         busy,
  input  gbn_sts_t                     sts_i,
  output gbn_cmd_t                     cmd_o,
  output logic [$clog2(MAX_BOXES)-1:0] rd_addr_o,
  output logic [$clog2(MAX_BOXES)-1:0] wr_addr_o,
  output logic [$clog2(MAX_BOXES)-1:0] kset_addr_o
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = AW + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SH_RD  = 4'd1;
  localparam logic [3:0] ST_SH_CMP = 4'd2;
  localparam logic [3:0] ST_I_RD   = 4'd3;
  localparam logic [3:0] ST_I_LAT  = 4'd4;
  localparam logic [3:0] ST_I_AREA = 4'd5;
  localparam logic [3:0] ST_J_ISS  = 4'd6;
  localparam logic [3:0] ST_DRAIN  = 4'd7;
  localparam logic [3:0] ST_O_RD   = 4'd8;
  localparam logic [3:0] ST_O_CHK  = 4'd9;
  localparam logic [3:0] ST_O_FIN  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] p_q, p_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [2:0]    drain_q, drain_d;
  logic          last_q, last_d;
  logic          ovf_q, ovf_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] i_inc;

  assign i_inc = i_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    p_d         = p_q;
    i_d         = i_q;
    j_d         = j_q;
    drain_d     = drain_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    cmd_o       = '0;
    cmd_o.ovf   = ovf_q;
    rd_addr_o   = i_q[AW-1:0];
    wr_addr_o   = p_q;
    kset_addr_o = count_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.nb_load = 1'b1;
          last_d        = last_box_i;
          i_d           = '0;
          if (count_q == CW'(MAX_BOXES)) begin
            ovf_d = 1'b1;
            if (last_box_i) begin
              state_d = ST_I_RD;
            end
          end else begin
            cmd_o.keep_set = 1'b1;
            p_d            = count_q[AW-1:0];
            state_d        = ST_SH_RD;
          end
        end
      end
      ST_SH_RD: begin
        rd_addr_o = p_q - AW'(1);
        if (p_q == '0) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel_new = 1'b1;
          count_d          = count_q + CW'(1);
          state_d          = last_q ? ST_I_RD : ST_IDLE;
        end else begin
          state_d = ST_SH_CMP;
        end
      end
      ST_SH_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.lt) begin
          p_d     = p_q - AW'(1);
          state_d = ST_SH_RD;
        end else begin
          cmd_o.wr_sel_new = 1'b1;
          count_d          = count_q + CW'(1);
          state_d          = last_q ? ST_I_RD : ST_IDLE;
        end
      end
      ST_I_RD: begin
        state_d = ST_I_LAT;
      end
      ST_I_LAT: begin
        cmd_o.lat_a = 1'b1;
        if (sts_i.keep_rd) begin
          state_d = ST_I_AREA;
        end else begin
          i_d     = (i_inc == count_q) ? '0 : i_inc;
          state_d = (i_inc == count_q) ? ST_O_RD : ST_I_RD;
        end
      end
      ST_I_AREA: begin
        cmd_o.lat_area = 1'b1;
        j_d            = i_inc;
        if (i_inc == count_q) begin
          i_d     = '0;
          state_d = ST_O_RD;
        end else begin
          state_d = ST_J_ISS;
        end
      end
      ST_J_ISS: begin
        rd_addr_o        = j_q[AW-1:0];
        cmd_o.pair_issue = 1'b1;
        j_d              = j_q + CW'(1);
        if (j_q + CW'(1) == count_q) begin
          drain_d = DRAIN_CYCLES;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q - 3'd1;
        if (drain_q == '0) begin
          i_d     = (i_inc == count_q) ? '0 : i_inc;
          state_d = (i_inc == count_q) ? ST_O_RD : ST_I_RD;
        end
      end
      ST_O_RD: begin
        state_d = ST_O_CHK;
      end
      ST_O_CHK: begin
        if (sts_i.keep_rd) begin
          cmd_o.emit      = pend_q;
          cmd_o.pend_load = 1'b1;
          pend_d          = 1'b1;
        end
        i_d     = i_inc;
        state_d = (i_inc == count_q) ? ST_O_FIN : ST_O_RD;
      end
      ST_O_FIN: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
        count_d         = '0;
        ovf_d           = 1'b0;
        pend_d          = 1'b0;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      p_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      drain_q <= '0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      p_q     <= p_d;
      i_q     <= i_d;
      j_q     <= j_d;
      drain_q <= drain_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  `GBN_ASSERT_IMPLY(a_count_cap, 1'b1, count_q <= CW'(MAX_BOXES))
  `GBN_ASSERT_IMPLY(a_pair_order, state_q == ST_J_ISS, (j_q > i_q) && (j_q < count_q))
  `GBN_ASSERT_NEXT(a_last_idle, cmd_o.emit && cmd_o.emit_last, (state_q == ST_IDLE) && (count_q == '0))
  `GBN_ASSERT_IMPLY(a_final_pending, state_q == ST_O_FIN, pend_q)

endmodule
